// ----- sv/sparse_polynomial_term_store_eval_defines.svh -----
// Assertion macros for the sparse polynomial term store.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef SPARSE_POLYNOMIAL_TERM_STORE_EVAL_DEFINES_SVH
`define SPARSE_POLYNOMIAL_TERM_STORE_EVAL_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define SPTS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define SPTS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define SPTS_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define SPTS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- sv/spts_pkg.sv -----
// Shared types and constants for the sparse polynomial term store.
// No dependencies.
`timescale 1ns / 1ps
package spts_pkg;
    localparam int TermSlotsDefault   = 16;
    localparam int MaxExponentDefault = 31;
    localparam int CoefW = 32;
    localparam int ExpW  = 5;

    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_DELETE = 2'd1,
        ACT_EVAL   = 2'd2,
        ACT_NONE   = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_RSVD      = 2'd3
    } status_t;

    typedef struct packed {
        logic [1:0]        action;
        logic signed [31:0] coefficient;
        logic [4:0]        exponent;
        logic signed [31:0] point;
    } cmd_t;

    typedef struct packed {
        logic [1:0]        status;
        logic signed [31:0] poly_value;
    } rsp_t;

    // term entry as stored in memory
    typedef struct packed {
        logic [CoefW-1:0] coef;
        logic [ExpW-1:0]  expo;
    } term_t;
endpackage

// ----- sv/spts_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module spts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ----- sv/sparse_polynomial_term_store_eval.sv -----
// Top level of the sparse polynomial term store with evaluation.
// Depends on spts_pkg, spts_ram and the assertion macro header.
//
// Usage: drive cmd and pulse start while busy is low; that edge accepts the
// transaction. busy stays high through the one cycle in which done marks the
// single result on rsp; the receiver cannot stall it.
// Terms live in one RAM (coefficient and exponent side by side) kept sorted
// by exponent, descending; term_count sits in a register.
// Steps per transaction, with E the exponent of a stored term:
//   insert: scan for the slot, then shift entries up with one
//           read-then-write pair per entry, then write the new term,
//   delete: scan, then shift entries down,
//   evaluate: for each stored term the term is read, the shared 32x32
//           multiplier forms point^E one product per cycle, one more
//           step forms the coefficient product and one adds it to the
//           sum.
// The single RAM port pair and the one multiplier set this sequencing.
// Reset clears term_count and the controller; memory contents are never
// read before written, so no clearing pass runs.
`timescale 1ns / 1ps
`include "sparse_polynomial_term_store_eval_defines.svh"
module sparse_polynomial_term_store_eval #(
    parameter int TERM_SLOTS   = spts_pkg::TermSlotsDefault,
    parameter int MAX_EXPONENT = spts_pkg::MaxExponentDefault
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  spts_pkg::cmd_t cmd,
    output logic           done,
    output spts_pkg::rsp_t rsp
);
    import spts_pkg::*;

    localparam int AW = $clog2(TERM_SLOTS);
    localparam int CW = $clog2(TERM_SLOTS + 1);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_SCAN  = 10'b0000000010,  // read issued for idx
        S_SCANW = 10'b0000000100,  // data for idx available
        S_MVRD  = 10'b0000001000,  // issue read for shift
        S_MVWR  = 10'b0000010000,  // write shifted entry
        S_PUT   = 10'b0000100000,  // write new term
        S_EVRD  = 10'b0001000000,
        S_POW   = 10'b0010000000,
        S_MAC   = 10'b0100000000,
        S_DONE  = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;
    cmd_t cmd_reg, cmd_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] idx_reg, idx_next;     // scan position
    logic [CW-1:0] mv_reg, mv_next;       // shift position
    logic [CoefW-1:0] pow_reg, pow_next;
    logic [ExpW-1:0] ecnt_reg, ecnt_next;
    logic [CoefW-1:0] coef_reg, coef_next;
    logic [CoefW-1:0] sum_reg, sum_next;
    logic [1:0] status_reg, status_next;
    logic [CoefW-1:0] prod_reg;

    logic we;
    logic [AW-1:0] waddr, raddr;
    term_t wdata, rdata;

    spts_ram #(.WIDTH($bits(term_t)), .DEPTH(TERM_SLOTS)) u_terms (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    // saturated insert exponent
    logic [ExpW-1:0] ins_exp;
    always_comb
    begin
        if ({1'b0, cmd_reg.exponent} > (ExpW+1)'(MAX_EXPONENT))
            ins_exp = ExpW'(MAX_EXPONENT);
        else
            ins_exp = cmd_reg.exponent;
    end

    // one shared multiplier: pow*point in S_POW, coef*pow in S_MAC
    logic [CoefW-1:0] mul_a, mul_b;
    always_comb
    begin
        mul_a = pow_reg;
        mul_b = (state_reg == S_MAC) ? coef_reg : cmd_reg.point;
    end
    logic [2*CoefW-1:0] mul_full;
    assign mul_full = mul_a * mul_b;
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_full[CoefW-1:0];
    end

    always_comb
    begin
        state_next  = state_reg;
        cmd_next    = cmd_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        mv_next     = mv_reg;
        pow_next    = pow_reg;
        ecnt_next   = ecnt_reg;
        coef_next   = coef_reg;
        sum_next    = sum_reg;
        status_next = status_reg;
        we = 1'b0;
        waddr = idx_reg[AW-1:0];
        wdata = '0;
        raddr = idx_reg[AW-1:0];
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next    = cmd;
                    idx_next    = '0;
                    sum_next    = '0;
                    status_next = ST_OK;
                    unique case (cmd.action) inside
                        ACT_INSERT:
                            if (count_reg == CW'(TERM_SLOTS))
                            begin
                                status_next = ST_FULL;
                                state_next  = S_DONE;
                            end
                            else
                                state_next = S_SCAN;
                        ACT_DELETE, ACT_EVAL:
                            state_next = S_SCAN;
                        default:
                            state_next = S_DONE;
                    endcase
                end
            end
            S_SCAN:
            begin
                // raddr = idx issued this cycle
                if (idx_reg >= count_reg)
                begin
                    if (cmd_reg.action == ACT_INSERT)
                    begin
                        mv_next    = count_reg;
                        state_next = (count_reg == idx_reg) ? S_PUT : S_MVRD;
                    end
                    else
                    begin
                        if (cmd_reg.action == ACT_DELETE)
                            status_next = ST_NOT_FOUND;
                        state_next = S_DONE;
                    end
                end
                else
                    state_next = S_SCANW;
            end
            S_SCANW:
            begin
                if (cmd_reg.action == ACT_INSERT)
                begin
                    if (ins_exp <= rdata.expo)
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        mv_next    = count_reg;
                        state_next = S_MVRD;
                    end
                end
                else if (cmd_reg.action == ACT_DELETE)
                begin
                    if (rdata.expo == cmd_reg.exponent)
                    begin
                        mv_next    = idx_reg;
                        state_next = S_MVRD;
                    end
                    else if (cmd_reg.exponent > rdata.expo)
                    begin
                        status_next = ST_NOT_FOUND;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = S_SCAN;
                    end
                end
                else
                begin
                    coef_next  = rdata.coef;
                    ecnt_next  = rdata.expo;
                    pow_next   = CoefW'(1);
                    state_next = (rdata.expo == '0) ? S_MAC : S_POW;
                end
            end
            S_MVRD:
            begin
                // insert: read mv-1, write to mv; delete: read mv+1, write to mv
                if (cmd_reg.action == ACT_INSERT)
                begin
                    if (mv_reg == idx_reg)
                        state_next = S_PUT;
                    else
                    begin
                        raddr      = AW'(mv_reg - 1'b1);
                        state_next = S_MVWR;
                    end
                end
                else
                begin
                    if (mv_reg + 1'b1 >= count_reg)
                    begin
                        count_next = count_reg - 1'b1;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        raddr      = AW'(mv_reg + 1'b1);
                        state_next = S_MVWR;
                    end
                end
            end
            S_MVWR:
            begin
                we    = 1'b1;
                waddr = mv_reg[AW-1:0];
                wdata = rdata;
                if (cmd_reg.action == ACT_INSERT)
                    mv_next = mv_reg - 1'b1;
                else
                    mv_next = mv_reg + 1'b1;
                state_next = S_MVRD;
            end
            S_PUT:
            begin
                we         = 1'b1;
                waddr      = idx_reg[AW-1:0];
                wdata.coef = cmd_reg.coefficient;
                wdata.expo = ins_exp;
                count_next = count_reg + 1'b1;
                state_next = S_DONE;
            end
            S_EVRD:
            begin
                // product of coef*pow ready in prod_reg
                sum_next   = sum_reg + prod_reg;
                idx_next   = idx_reg + 1'b1;
                state_next = S_SCAN;
            end
            S_POW:
            begin
                // advance the power by one factor of point per cycle
                pow_next  = mul_full[CoefW-1:0];
                ecnt_next = ecnt_reg - 1'b1;
                if (ecnt_reg == ExpW'(1))
                    state_next = S_MAC;
            end
            S_MAC:
            begin
                state_next = S_EVRD;
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            status_reg <= ST_OK;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            status_reg <= status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        idx_reg  <= idx_next;
        mv_reg   <= mv_next;
        ecnt_reg <= ecnt_next;
        coef_reg <= coef_next;
        sum_reg  <= sum_next;
        pow_reg  <= pow_next;
    end

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_DONE);
    assign rsp.status     = status_reg;
    assign rsp.poly_value = (cmd_reg.action == ACT_EVAL) ? sum_reg : '0;

    `SPTS_ASSERT_IMPL(a_count_bound, clk, rst_n, 1'b1, count_reg <= CW'(TERM_SLOTS))
    `SPTS_ASSERT_NEXT(a_done_pulse, clk, rst_n, done, !done)
    `SPTS_ASSERT_NEXT(a_start_busy, clk, rst_n, start && !busy, busy)
    `SPTS_ASSERT_IMPL(a_write_range, clk, rst_n, we, waddr <= AW'(TERM_SLOTS - 1))
endmodule

// ----- tb/sv/sparse_polynomial_term_store_eval_checker.sv -----
// Checker for the sparse polynomial term store: predicts each response from
// accepted commands and compares it with what the block returns.
// Depends on spts_pkg.
`timescale 1ns / 1ps
module sparse_polynomial_term_store_eval_checker #(
    parameter int TERM_SLOTS   = spts_pkg::TermSlotsDefault,
    parameter int MAX_EXPONENT = spts_pkg::MaxExponentDefault
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic           busy,
    input  spts_pkg::cmd_t cmd,
    input  logic           done,
    input  spts_pkg::rsp_t rsp,
    output int             fail_count,
    output int             pending
);
    import spts_pkg::*;

    logic [31:0] coef_tbl [TERM_SLOTS];
    logic [4:0]  expo_tbl [TERM_SLOTS];
    int          n_terms;
    rsp_t        expected_rsp [$];

    function automatic logic [31:0] int_power(logic [31:0] b, logic [4:0] e);
        logic [31:0] acc;
        acc = 32'd1;
        for (int i = 0; i < e; i++)
            acc = acc * b;
        return acc;
    endfunction

    // Update the shadow table and return the response the block must give.
    function automatic rsp_t apply_command(cmd_t c);
        rsp_t r;
        int   pos;
        logic [4:0] e;
        r = '0;
        r.status = ST_OK;
        case (action_t'(c.action))
            ACT_INSERT:
            begin
                if (n_terms >= TERM_SLOTS)
                    r.status = ST_FULL;
                else
                begin
                    e = (c.exponent > MAX_EXPONENT) ? 5'(MAX_EXPONENT) : c.exponent;
                    pos = 0;
                    while (pos < n_terms && e <= expo_tbl[pos])
                        pos++;
                    for (int i = n_terms; i > pos; i--)
                    begin
                        coef_tbl[i] = coef_tbl[i-1];
                        expo_tbl[i] = expo_tbl[i-1];
                    end
                    coef_tbl[pos] = c.coefficient;
                    expo_tbl[pos] = e;
                    n_terms++;
                end
            end
            ACT_DELETE:
            begin
                pos = -1;
                for (int i = 0; i < n_terms; i++)
                begin
                    if (expo_tbl[i] == c.exponent)
                    begin
                        pos = i;
                        break;
                    end
                    if (c.exponent > expo_tbl[i])
                        break;
                end
                if (pos < 0)
                    r.status = ST_NOT_FOUND;
                else
                begin
                    for (int i = pos; i + 1 < n_terms; i++)
                    begin
                        coef_tbl[i] = coef_tbl[i+1];
                        expo_tbl[i] = expo_tbl[i+1];
                    end
                    n_terms--;
                end
            end
            ACT_EVAL:
                for (int i = 0; i < n_terms; i++)
                    r.poly_value = r.poly_value + coef_tbl[i] * int_power(c.point, expo_tbl[i]);
            default: ;
        endcase
        return r;
    endfunction

    assign pending = expected_rsp.size();

    always @(posedge clk or negedge rst_n)
    begin
        rsp_t want;
        if (!rst_n)
        begin
            n_terms = 0;
            fail_count = 0;
            expected_rsp.delete();
        end
        else
        begin
            // Compare first: a response never shares an edge with its own command.
            if (done)
            begin
                if (expected_rsp.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected response status=%0d value=%0d",
                                 rsp.status, rsp.poly_value);
                end
                else
                begin
                    want = expected_rsp.pop_front();
                    if (rsp.status !== want.status || rsp.poly_value !== want.poly_value)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: exp status=%0d value=%0d, got status=%0d value=%0d",
                                     want.status, want.poly_value, rsp.status, rsp.poly_value);
                    end
                end
            end
            if (start && !busy)
                expected_rsp.push_back(apply_command(cmd));
        end
    end
endmodule

// ----- tb/sv/sparse_polynomial_term_store_eval_tb.sv -----
// Testbench top for the sparse polynomial term store: drives directed and
// random commands under several idle patterns and gives the verdict.
// Depends on spts_pkg, the block and sparse_polynomial_term_store_eval_checker.
`timescale 1ns / 1ps
module sparse_polynomial_term_store_eval_tb;
    import spts_pkg::*;

    localparam int WatchdogLimit = 20000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic done;
    cmd_t cmd = '0;
    rsp_t rsp;
    int   fail_count;
    int   pending;
    int   idle_pct = 0;
    int   stall_cycles = 0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    sparse_polynomial_term_store_eval u_top (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .cmd(cmd), .done(done), .rsp(rsp)
    );

    sparse_polynomial_term_store_eval_checker u_chk (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .cmd(cmd),
        .done(done), .rsp(rsp), .fail_count(fail_count), .pending(pending)
    );

    // Watchdog: count cycles with no accepted transaction on either side.
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WatchdogLimit)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Issue one transaction: optional random gap, then hold start until accepted.
    task automatic issue(action_t a, logic [31:0] coef, logic [4:0] e, logic [31:0] pt);
        while (idle_pct > 0 && $urandom_range(99) < idle_pct)
            @(negedge clk);
        cmd.action      = a;
        cmd.coefficient = coef;
        cmd.exponent    = e;
        cmd.point       = pt;
        start = 1'b1;
        do
            @(posedge clk);
        while (busy);
        @(negedge clk);
        start = 1'b0;
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'hFFFF_FFFF;
            3: return 32'(int'($urandom_range(6)) - 3);
            default: return $urandom;
        endcase
    endfunction

    // Mostly small exponents keep evaluation latency moderate.
    function automatic logic [4:0] rand_expo();
        return ($urandom_range(9) == 0) ? 5'($urandom) : 5'($urandom_range(6));
    endfunction

    initial
    begin
        int r;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: empty table, unused action, extremes, zero exponent, full table.
        issue(ACT_EVAL,   0, 0, 32'd5);
        issue(ACT_DELETE, 0, 5'd3, 0);
        issue(ACT_NONE,   32'hFFFF_FFFF, 5'd31, 32'hFFFF_FFFF);
        issue(ACT_INSERT, 32'h7FFF_FFFF, 5'd0, 0);
        issue(ACT_INSERT, 32'h8000_0000, 5'd31, 0);
        issue(ACT_INSERT, 32'd3, 5'd31, 0);
        issue(ACT_INSERT, 32'hFFFF_FFFF, 5'd7, 0);
        issue(ACT_EVAL,   0, 0, 32'd0);
        issue(ACT_EVAL,   0, 0, 32'h8000_0000);
        issue(ACT_EVAL,   0, 0, 32'h7FFF_FFFF);
        issue(ACT_EVAL,   0, 0, 32'hFFFF_FFFF);
        for (int i = 0; i < 12; i++)
            issue(ACT_INSERT, $urandom, 5'($urandom_range(4)), 0);
        issue(ACT_INSERT, 32'd1, 5'd2, 0);
        issue(ACT_DELETE, 0, 5'd31, 0);
        issue(ACT_DELETE, 0, 5'd30, 0);
        issue(ACT_EVAL,   0, 0, 32'd2);

        // Pause until every expected response has come.
        while (pending != 0)
            @(negedge clk);

        // Random phases: no idling, sender idle 50%, then 28%, then no idling again.
        for (int ph = 0; ph < 4; ph++)
        begin
            idle_pct = (ph == 1) ? 50 : (ph == 2) ? 28 : 0;
            for (int i = 0; i < 380; i++)
            begin
                r = $urandom_range(99);
                if (r < 42)
                    issue(ACT_INSERT, rand_word(), rand_expo(), rand_word());
                else if (r < 72)
                    issue(ACT_DELETE, rand_word(), rand_expo(), rand_word());
                else if (r < 97)
                    issue(ACT_EVAL, rand_word(), 5'($urandom), rand_word());
                else
                    issue(ACT_NONE, rand_word(), 5'($urandom), rand_word());
            end
        end

        while (pending != 0)
            @(negedge clk);
        repeat (100) @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule

// ----- sim.f -----
+incdir+sv
sv/spts_pkg.sv
sv/spts_ram.sv
sv/sparse_polynomial_term_store_eval.sv
tb/sv/sparse_polynomial_term_store_eval_checker.sv
tb/sv/sparse_polynomial_term_store_eval_tb.sv
